// ===== rtl/alarm_relay_vote_ack_controller_macros.svh =====
// ----------------------------------------------------------------------------
// Alarm relay vote and acknowledge controller: assertion macros
// Shared concurrent assertion forms for the controller's RTL.
// ----------------------------------------------------------------------------
`ifndef ALARM_RELAY_VOTE_ACK_CONTROLLER_MACROS_SVH
`define ALARM_RELAY_VOTE_ACK_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ARVAC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arvac assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ARVAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arvac assertion failed");

`endif

// ===== rtl/arvac_pkg.sv =====
// ----------------------------------------------------------------------------
// Alarm relay vote and acknowledge controller: package
// Sizes, codes and word types shared by the controller's modules.
// ----------------------------------------------------------------------------
package arvac_pkg;

   localparam int SENSOR_COUNT = 32;
   localparam int RELAY_COUNT  = 16;

   localparam int MASK_BITS  = 32;
   localparam int INDEX_BITS = 4;
   localparam int COUNT_BITS = 6;
   localparam int DELAY_BITS = 8;
   localparam int KIND_BITS  = 2;
   localparam int LEVEL_BITS = 2;

   localparam logic [KIND_BITS-1:0] KIND_OTHER = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LIGHT = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_SOUND = 2'd2;

   localparam logic [DELAY_BITS-1:0] ACK_HOLD_RESET = 8'd10;

   typedef struct packed {
      logic [INDEX_BITS-1:0] relay_index;
      logic [MASK_BITS-1:0]  mask_low;
      logic [MASK_BITS-1:0]  mask_high;
      logic [MASK_BITS-1:0]  warn_low_bits;
      logic [MASK_BITS-1:0]  warn_high_bits;
      logic [COUNT_BITS-1:0] required_count;
      logic [DELAY_BITS-1:0] delay_limit;
      logic [KIND_BITS-1:0]  relay_kind;
      logic                  test_press;
      logic                  silence_press;
   } request_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] relay_number;
      logic                  relay_on;
      logic                  muted;
   } response_type;

   // Vote result handed from the sensor compare to the relay state logic.
   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [MASK_BITS-1:0]  snap_low;
      logic [MASK_BITS-1:0]  snap_high;
   } vote_type;

endpackage

// ===== rtl/alarm_relay_vote_ack_controller.sv =====
// ----------------------------------------------------------------------------
// Alarm relay vote and acknowledge controller
// Evaluates one alarm relay per word against its sensors and per-relay state.
// ----------------------------------------------------------------------------
// The controller takes one request word in every clock cycle: a word is taken
// at each rising edge where start is high and busy is low, and busy is high
// only while reset is asserted. Each request produces exactly one response
// word, registered in the request register and then the response register,
// shown on rsp_word for a single cycle while rsp_strobe is high. The receiver
// cannot stall the response, so it must capture every strobed word in the
// cycle it appears. The sensor compare, the qualifier count and the per-relay
// state update all sit in the one combinational stage between those
// registers. Requests for the same relay may come back to back, because each
// relay's state is written at the same edge that captures its response. The
// hold time for acknowledgements is set through csr_write_enable and
// csr_write_data, and should only be changed while no request is in flight.
// ----------------------------------------------------------------------------
`include "alarm_relay_vote_ack_controller_macros.svh"

module alarm_relay_vote_ack_controller
   import arvac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  request_type           req_word,
   output logic                  rsp_strobe,
   output response_type          rsp_word,
   input  logic                  csr_write_enable,
   input  logic [DELAY_BITS-1:0] csr_write_data
);

   logic                  req_valid_ff;
   request_type           req_ff;
   logic                  rsp_valid_ff;
   response_type          rsp_ff;
   response_type          rsp_in;
   logic [DELAY_BITS-1:0] hold_ticks_ff;
   vote_type              vote;
   logic                  relay_on;
   logic                  muted;

   // No words are taken while reset clears the relay state.
   assign busy = reset;

   // Hold time register for the acknowledgement re-arm logic.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= ACK_HOLD_RESET;
      end else if (csr_write_enable) begin
         hold_ticks_ff <= csr_write_data;
      end
   end

   // Request register: the first of the two pipeline registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_word;
      end
   end

   arvac_sensor_vote u_vote (
      .req  (req_ff),
      .vote (vote)
   );

   arvac_relay_state u_state (
      .clock      (clock),
      .reset      (reset),
      .valid      (req_valid_ff),
      .req        (req_ff),
      .vote       (vote),
      .hold_ticks (hold_ticks_ff),
      .relay_on   (relay_on),
      .muted      (muted)
   );

   always_comb begin
      rsp_in.relay_number = req_ff.relay_index;
      rsp_in.relay_on     = relay_on;
      rsp_in.muted        = muted;
   end

   // Response register: the strobe lasts exactly one cycle per request.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   // Every accepted word enters the request stage on the next cycle.
   `ARVAC_ASSERT_NEXT(a_accept_loads, clock, reset, start && !busy, req_valid_ff)
   // Every request stage word leaves as a strobed response in the following cycle.
   `ARVAC_ASSERT_NEXT(a_stage_responds, clock, reset, req_valid_ff, rsp_strobe)
   // The response echoes the relay that was in the request stage.
   `ARVAC_ASSERT_SAME(a_echo_relay, clock, reset, rsp_strobe,
                      rsp_word.relay_number == $past(req_ff.relay_index))
   // A muted relay is only energized by the test button.
   `ARVAC_ASSERT_SAME(a_muted_off, clock, reset,
                      rsp_strobe && rsp_word.muted && rsp_word.relay_on,
                      $past(req_ff.test_press))

endmodule

// ===== rtl/arvac_sensor_vote.sv =====
// ----------------------------------------------------------------------------
// Alarm relay sensor vote
// Compares each sensor's level with its required level and counts qualifiers.
// ----------------------------------------------------------------------------
module arvac_sensor_vote
   import arvac_pkg::*;
(
   input  request_type req,
   output vote_type    vote
);

   logic [SENSOR_COUNT-1:0] qualify;
   logic [COUNT_BITS-1:0]   count;

   always_comb begin
      for (int j = 0; j < SENSOR_COUNT; j++) begin
         qualify[j] = ({req.mask_high[j], req.mask_low[j]} != 2'd0) &&
                      ({req.warn_high_bits[j], req.warn_low_bits[j]} >=
                       {req.mask_high[j], req.mask_low[j]});
      end
   end

   always_comb begin
      count = '0;
      for (int j = 0; j < SENSOR_COUNT; j++) begin
         count = count + COUNT_BITS'(qualify[j]);
      end
   end

   // Sensors beyond the supported count contribute nothing to the snapshot.
   always_comb begin
      vote.count     = count;
      vote.snap_low  = '0;
      vote.snap_high = '0;
      vote.snap_low[SENSOR_COUNT-1:0]  = req.warn_low_bits[SENSOR_COUNT-1:0] & qualify;
      vote.snap_high[SENSOR_COUNT-1:0] = req.warn_high_bits[SENSOR_COUNT-1:0] & qualify;
   end

endmodule

// ===== rtl/arvac_relay_state.sv =====
// ----------------------------------------------------------------------------
// Alarm relay state
// Per-relay delay counters and acknowledgement snapshots, updated in one pass.
// ----------------------------------------------------------------------------
module arvac_relay_state
   import arvac_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid,
   input  request_type           req,
   input  vote_type              vote,
   input  logic [DELAY_BITS-1:0] hold_ticks,
   output logic                  relay_on,
   output logic                  muted
);

   logic [DELAY_BITS-1:0] delay_count_ff [RELAY_COUNT];
   logic [MASK_BITS-1:0]  ack_low_ff     [RELAY_COUNT];
   logic [MASK_BITS-1:0]  ack_high_ff    [RELAY_COUNT];
   logic [DELAY_BITS-1:0] ack_timer_ff   [RELAY_COUNT];

   logic [DELAY_BITS-1:0] delay_count_in;
   logic [MASK_BITS-1:0]  ack_low_in;
   logic [MASK_BITS-1:0]  ack_high_in;
   logic [DELAY_BITS-1:0] ack_timer_in;

   logic [DELAY_BITS-1:0] cur_delay;
   logic [MASK_BITS-1:0]  cur_low;
   logic [MASK_BITS-1:0]  cur_high;
   logic [DELAY_BITS-1:0] cur_timer;
   logic [DELAY_BITS-1:0] timer_inc;
   logic                  rise;
   logic                  fall;
   logic                  vote_met;

   assign cur_delay = delay_count_ff[req.relay_index];
   assign cur_low   = ack_low_ff[req.relay_index];
   assign cur_high  = ack_high_ff[req.relay_index];
   assign cur_timer = ack_timer_ff[req.relay_index];

   // A rise anywhere above the snapshot drops it; a fall marks it as unequal.
   always_comb begin
      rise = 1'b0;
      fall = 1'b0;
      for (int j = 0; j < MASK_BITS; j++) begin
         if ({vote.snap_high[j], vote.snap_low[j]} > {cur_high[j], cur_low[j]}) begin
            rise = 1'b1;
         end
         if ({vote.snap_high[j], vote.snap_low[j]} < {cur_high[j], cur_low[j]}) begin
            fall = 1'b1;
         end
      end
   end

   assign vote_met  = vote.count >= req.required_count;
   assign timer_inc = DELAY_BITS'(cur_timer + 8'd1);

   always_comb begin
      delay_count_in = cur_delay;
      ack_low_in     = cur_low;
      ack_high_in    = cur_high;
      ack_timer_in   = cur_timer;
      relay_on       = 1'b0;
      if (rise) begin
         ack_low_in  = '0;
         ack_high_in = '0;
      end
      if ((ack_low_in == '0) && (ack_high_in == '0)) begin
         if ((vote.count != '0) && vote_met) begin
            if (cur_delay >= req.delay_limit) begin
               if ((req.relay_kind == KIND_SOUND) && req.silence_press) begin
                  ack_low_in     = vote.snap_low;
                  ack_high_in    = vote.snap_high;
                  ack_timer_in   = '0;
                  delay_count_in = '0;
               end else begin
                  relay_on = 1'b1;
               end
            end else begin
               delay_count_in = DELAY_BITS'(cur_delay + 8'd1);
            end
         end else begin
            delay_count_in = '0;
         end
      end else if (!fall) begin
         ack_timer_in = '0;
      end else if (timer_inc > hold_ticks) begin
         ack_low_in   = vote_met ? vote.snap_low  : '0;
         ack_high_in  = vote_met ? vote.snap_high : '0;
         ack_timer_in = '0;
      end else begin
         ack_timer_in = timer_inc;
      end
      if (((req.relay_kind == KIND_LIGHT) || (req.relay_kind == KIND_SOUND)) &&
          req.test_press) begin
         relay_on = 1'b1;
      end
      muted = (ack_low_in != '0) || (ack_high_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < RELAY_COUNT; r++) begin
            delay_count_ff[r] <= '0;
            ack_low_ff[r]     <= '0;
            ack_high_ff[r]    <= '0;
            ack_timer_ff[r]   <= '0;
         end
      end else if (valid) begin
         delay_count_ff[req.relay_index] <= delay_count_in;
         ack_low_ff[req.relay_index]     <= ack_low_in;
         ack_high_ff[req.relay_index]    <= ack_high_in;
         ack_timer_ff[req.relay_index]   <= ack_timer_in;
      end
   end

endmodule
